@@ hw/rtl/rcid_pkg.sv @@
// Shared types and codes for the reference-counted ID allocator.
// No dependencies; imported by the controller, datapath and top level.
package rcid_pkg;

   typedef enum logic [1:0] {
      OP_ALLOCATE = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_ADD_REF  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_ID      = 2'd1,
      ST_STACK_FULL = 2'd2,
      ST_SATURATED  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch request, launch memory reads
      logic execute;   // update state, register result
   } cmd_type;

   localparam int ID_W = 8;

endpackage

@@ hw/rtl/refcounted_id_allocator.sv @@
// Reference-counted ID allocator: free stack plus per-ID holder counts.
// Requests do not overlap: after the registered read of the stack and holder-count
// memories, busy holds off the next request during their write-back, and the result
// strobe rsp_valid is registered.
// Reset (synchronous): stack empty, fresh counter zero, all holder counts cleared
// at once by per-entry valid flags. Results cannot be stalled by the receiver.
module refcounted_id_allocator #(
   parameter int ID_COUNT   = 256,
   parameter int COUNT_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel: transfer when start && !busy
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_operation,
   input  logic [rcid_pkg::ID_W-1:0]  req_id,
   // response channel: one-cycle strobe, always taken
   output logic                       rsp_valid,
   output logic [rcid_pkg::ID_W-1:0]  rsp_given_id,
   output logic                       rsp_returned_to_pool,
   output logic [1:0]                 rsp_status
);
   import rcid_pkg::*;

   cmd_type cmd;

   // Sequence the registered read and the write-back of each request.
   rcid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Hold the stack, holder counts and fresh counter; register the result.
   rcid_dp #(
      .ID_COUNT   (ID_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_operation        (req_operation),
      .req_id               (req_id),
      .rsp_valid            (rsp_valid),
      .rsp_given_id         (rsp_given_id),
      .rsp_returned_to_pool (rsp_returned_to_pool),
      .rsp_status           (rsp_status)
   );

endmodule

@@ hw/rtl/rcid_ctrl.sv @@
// Controller state machine for the ID allocator.
// Depends on rcid_pkg (state and command types).
module rcid_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output rcid_pkg::cmd_type cmd
);
   import rcid_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
         end
         S_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/rcid_dp.sv @@
// Datapath of the ID allocator: free stack, holder counts, fresh counter, result.
// Depends on rcid_pkg (codes and command type).
module rcid_dp #(
   parameter int ID_COUNT   = 256,
   parameter int COUNT_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rcid_pkg::cmd_type          cmd,
   input  logic [1:0]                 req_operation,
   input  logic [rcid_pkg::ID_W-1:0]  req_id,
   output logic                       rsp_valid,
   output logic [rcid_pkg::ID_W-1:0]  rsp_given_id,
   output logic                       rsp_returned_to_pool,
   output logic [1:0]                 rsp_status
);
   import rcid_pkg::*;

   localparam int HC_DEPTH  = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
   localparam int HC_BITS   = $clog2(HC_DEPTH);
   localparam int SP_BITS   = $clog2(ID_COUNT);
   localparam int FILL_BITS = $clog2(ID_COUNT + 1);
   localparam logic [FILL_BITS-1:0]  FILL_MAX  = FILL_BITS'(ID_COUNT);
   localparam logic [ID_W:0]         ID_LIMIT  = (ID_W + 1)'(HC_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // memories
   logic [ID_W-1:0]       stk_mem [ID_COUNT];
   logic [COUNT_BITS-1:0] hc_mem  [HC_DEPTH];
   logic [HC_DEPTH-1:0]   hc_vld_ff;

   logic [FILL_BITS-1:0]  fill_ff;
   logic [FILL_BITS-1:0]  fill_in;
   logic [FILL_BITS-1:0]  fresh_ff;
   logic [FILL_BITS-1:0]  fresh_in;

   logic [1:0]            op_ff;
   logic [ID_W-1:0]       id_ff;
   logic [ID_W-1:0]       stk_rd_ff;
   logic [COUNT_BITS-1:0] hc_rd_ff;

   logic                  rsp_valid_ff;
   logic [ID_W-1:0]       given_ff;
   logic [ID_W-1:0]       given_in;
   logic                  back_ff;
   logic                  back_in;
   status_type            status_ff;
   status_type            status_in;

   logic                  hc_we;
   logic                  hc_wvld;
   logic [COUNT_BITS-1:0] hc_wdata;
   logic                  stk_we;

   logic [FILL_BITS-1:0]  fill_dec;
   logic [SP_BITS-1:0]    stk_raddr;
   logic [HC_BITS-1:0]    hc_addr;
   logic [COUNT_BITS-1:0] count;
   logic                  id_ok;
   logic [FILL_BITS+ID_W-1:0] fresh_ext;

   assign fill_dec  = fill_ff - 1'b1;
   assign stk_raddr = fill_dec[SP_BITS-1:0];
   assign hc_addr   = id_ff[HC_BITS-1:0];
   assign count     = hc_vld_ff[hc_addr] ? hc_rd_ff : '0;
   assign id_ok     = {1'b0, id_ff} < ID_LIMIT;
   assign fresh_ext = {{ID_W{1'b0}}, fresh_ff};

   // request capture and registered memory reads
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         id_ff     <= req_id;
         stk_rd_ff <= stk_mem[stk_raddr];
         hc_rd_ff  <= hc_mem[req_id[HC_BITS-1:0]];
      end
   end

   // operation decode
   always_comb begin
      fill_in   = fill_ff;
      fresh_in  = fresh_ff;
      given_in  = '0;
      back_in   = 1'b0;
      status_in = ST_OK;
      hc_we     = 1'b0;
      hc_wvld   = 1'b0;
      hc_wdata  = '0;
      stk_we    = 1'b0;
      case (op_ff)
         OP_ALLOCATE: begin
            if (fill_ff != '0) begin
               fill_in  = fill_dec;
               given_in = stk_rd_ff;
            end else if (fresh_ff < FILL_MAX) begin
               fresh_in = fresh_ff + 1'b1;
               given_in = fresh_ext[ID_W-1:0];
            end else begin
               status_in = ST_NO_ID;
            end
         end
         OP_RELEASE: begin
            if (id_ok) begin
               if (count > COUNT_ONE) begin
                  hc_we    = 1'b1;
                  hc_wvld  = 1'b1;
                  hc_wdata = count - 1'b1;
               end else begin
                  // last holder gone: drop the entry and push the ID if the stack has room
                  hc_we = 1'b1;
                  if (fill_ff < FILL_MAX) begin
                     stk_we  = 1'b1;
                     fill_in = fill_ff + 1'b1;
                     back_in = 1'b1;
                  end else begin
                     status_in = ST_STACK_FULL;
                  end
               end
            end
         end
         OP_ADD_REF: begin
            if (id_ok) begin
               if (count == '0) begin
                  hc_we    = 1'b1;
                  hc_wvld  = 1'b1;
                  hc_wdata = COUNT_TWO;
               end else if (count == COUNT_MAX) begin
                  status_in = ST_SATURATED;
               end else begin
                  hc_we    = 1'b1;
                  hc_wvld  = 1'b1;
                  hc_wdata = count + 1'b1;
               end
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.execute && stk_we) begin
         stk_mem[fill_ff[SP_BITS-1:0]] <= id_ff;
      end
      if (cmd.execute && hc_we && hc_wvld) begin
         hc_mem[hc_addr] <= hc_wdata;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         fresh_ff     <= '0;
         hc_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
         if (cmd.execute) begin
            fill_ff  <= fill_in;
            fresh_ff <= fresh_in;
            if (hc_we) hc_vld_ff[hc_addr] <= hc_wvld;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         given_ff  <= given_in;
         back_ff   <= back_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_given_id         = given_ff;
   assign rsp_returned_to_pool = back_ff;
   assign rsp_status           = status_ff;

endmodule

@@ hw/rtl/rcid_checker.sv @@
// Port-level checks for the ID allocator, bound to the top level.
// Depends on rcid_pkg (status codes) and refcounted_id_allocator.
module rcid_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [rcid_pkg::ID_W-1:0] rsp_given_id,
   input logic                      rsp_returned_to_pool,
   input logic [1:0]                rsp_status
);
   import rcid_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("no response two cycles after transfer");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response without a preceding busy cycle");

   a_given_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_given_id != '0) |-> (rsp_status == ST_OK && !rsp_returned_to_pool))
      else $error("given ID with error status or pool return");

   a_back_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_returned_to_pool) |-> (rsp_status == ST_OK))
      else $error("pool return with error status");

endmodule

bind refcounted_id_allocator rcid_checker u_rcid_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_given_id         (rsp_given_id),
   .rsp_returned_to_pool (rsp_returned_to_pool),
   .rsp_status           (rsp_status)
);

@@ dv/refcounted_id_allocator_tb.sv @@
// Self-checking bench for refcounted_id_allocator: directed table, then random traffic segments.
// Depends on rcid_pkg (op and status codes, ID_W) and the refcounted_id_allocator RTL only.
module refcounted_id_allocator_tb;
   import rcid_pkg::*;

   localparam int ID_COUNT      = 256;
   localparam int COUNT_BITS    = 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);
   localparam logic [1:0] OP_UNUSED = 2'd3;    // no operation behind this code
   localparam int RANDOM_ITEMS  = 1060;
   localparam int QUIET_TAIL    = 150;         // last random items go out back to back
   localparam int HELD_DEPTH    = 64;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 4;           // result strobe trails the transfer through the execute state

   typedef struct packed {
      logic [ID_W-1:0] given_id;
      logic            returned;
      status_type      status;
   } outcome_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [ID_W-1:0] id;
      int              reps;
      logic            typed;      // expected outcome below is written out by hand
      outcome_type     outcome;
   } stim_row_type;

   typedef enum int {
      SEG_ALLOC, SEG_RELEASE, SEG_REFCOUNT, SEG_HAMMER, SEG_NOISE
   } segment_kind_type;

   // Directed walk: fresh IDs, LIFO reuse, reference counting, unused code,
   // saturation, exhaustion, stack full with and without a count entry.
   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_ALLOCATE, 8'h00,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_ALLOCATE, 8'hFF,   1, 1'b1, '{8'h01, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h01,   1, 1'b1, '{8'h00, 1'b1, ST_OK}},
      '{OP_ALLOCATE, 8'h00,   1, 1'b1, '{8'h01, 1'b0, ST_OK}},
      '{OP_ADD_REF,  8'h01,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h01,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h01,   1, 1'b1, '{8'h00, 1'b1, ST_OK}},
      '{OP_UNUSED,   8'hFF,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_UNUSED,   8'h00,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_ADD_REF,  8'hFF, 254, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_ADD_REF,  8'hFF,   1, 1'b1, '{8'h00, 1'b0, ST_SATURATED}},
      '{OP_RELEASE,  8'hFF,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_ALLOCATE, 8'h5A, 255, 1'b0, '{8'h00, 1'b0, ST_OK}},
      '{OP_ALLOCATE, 8'hA5,   1, 1'b1, '{8'h00, 1'b0, ST_NO_ID}},
      '{OP_RELEASE,  8'h00, 256, 1'b1, '{8'h00, 1'b1, ST_OK}},
      '{OP_RELEASE,  8'h00,   1, 1'b1, '{8'h00, 1'b0, ST_STACK_FULL}},
      '{OP_ADD_REF,  8'h07,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h07,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h07,   1, 1'b1, '{8'h00, 1'b0, ST_STACK_FULL}},
      '{OP_ALLOCATE, 8'h00,   1, 1'b1, '{8'h00, 1'b0, ST_OK}},
      '{OP_ADD_REF,  8'h07,   1, 1'b0, '{8'h00, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h07,   1, 1'b0, '{8'h00, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h07,   1, 1'b0, '{8'h00, 1'b0, ST_OK}},
      '{OP_ALLOCATE, 8'h00,   1, 1'b0, '{8'h00, 1'b0, ST_OK}},
      '{OP_RELEASE,  8'h80,   1, 1'b0, '{8'h00, 1'b0, ST_OK}}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_operation = '0;
   logic [ID_W-1:0]     req_id = '0;
   logic                rsp_valid;
   logic [ID_W-1:0]     rsp_given_id;
   logic                rsp_returned_to_pool;
   logic [1:0]          rsp_status;

   // Hand-written expectation that travels with the request on the bus.
   logic                typed_valid = 1'b0;
   outcome_type         typed_outcome = '0;

   // Predictor state: fresh counter, free stack and holder counts.
   int                  fresh_next;
   int                  stack_depth;
   logic [ID_W-1:0]     free_ids [ID_COUNT];
   logic [COUNT_BITS-1:0] holders [ID_COUNT];

   outcome_type         expected_outcomes [$];
   logic [ID_W-1:0]     held_ids [$];
   int                  mismatches = 0;
   int                  transfers = 0;
   int                  results = 0;
   int                  seen_no_id = 0;
   int                  seen_full = 0;
   int                  seen_saturated = 0;
   int                  seen_pushed = 0;
   int                  stalled_cycles = 0;

   refcounted_id_allocator #(
      .ID_COUNT   (ID_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_id               (req_id),
      .rsp_valid            (rsp_valid),
      .rsp_given_id         (rsp_given_id),
      .rsp_returned_to_pool (rsp_returned_to_pool),
      .rsp_status           (rsp_status)
   );

   always #1 clock = ~clock;

   // Apply one request to the predictor state and return what the block must answer.
   function automatic outcome_type allocator_step(input logic [1:0] op,
                                                  input logic [ID_W-1:0] id);
      outcome_type           o;
      logic [COUNT_BITS-1:0] c;
      o = '{given_id: '0, returned: 1'b0, status: ST_OK};
      case (op)
         OP_ALLOCATE: begin
            // pop the most recently freed ID first, fall back to a fresh one
            if (stack_depth > 0) begin
               stack_depth--;
               o.given_id = free_ids[stack_depth];
            end else if (fresh_next < ID_COUNT) begin
               o.given_id = fresh_next[ID_W-1:0];
               fresh_next++;
            end else begin
               o.status = ST_NO_ID;
            end
         end
         OP_RELEASE: begin
            c = holders[id];
            if (c > 1) begin
               holders[id] = c - 1'b1;
            end else begin
               // last holder gone (or none recorded): clear the entry, then push if there is room
               holders[id] = '0;
               if (stack_depth < ID_COUNT) begin
                  free_ids[stack_depth] = id;
                  stack_depth++;
                  o.returned = 1'b1;
               end else begin
                  o.status = ST_STACK_FULL;
               end
            end
         end
         OP_ADD_REF: begin
            c = holders[id];
            if (c == 0) holders[id] = COUNT_TWO;
            else if (c == COUNT_MAX) o.status = ST_SATURATED;
            else holders[id] = c + 1'b1;
         end
         default: ;
      endcase
      return o;
   endfunction

   // Monitor: predict on every transfer, check every strobed result.
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset) begin
         if (start && !busy) begin
            transfers++;
            got = allocator_step(req_operation, req_id);
            if (typed_valid) got = typed_outcome;
            expected_outcomes.insert(expected_outcomes.size(), got);
            // remember handed-out IDs so the stimulus can reference and release them
            if (req_operation == OP_ALLOCATE && got.status == ST_OK) begin
               held_ids.insert(held_ids.size(), got.given_id);
               if (held_ids.size() > HELD_DEPTH) held_ids.delete(0);
            end
         end
         if (rsp_valid) begin
            results++;
            if (expected_outcomes.size() == 0) begin
               $error("result with nothing expected: given_id %0d, returned %0b, status %0d",
                      rsp_given_id, rsp_returned_to_pool, rsp_status);
               mismatches++;
            end else begin
               want = expected_outcomes[0];
               expected_outcomes.delete(0);
               if (rsp_given_id !== want.given_id) begin
                  $error("given_id: expected %0d, actual %0d", want.given_id, rsp_given_id);
                  mismatches++;
               end
               if (rsp_returned_to_pool !== want.returned) begin
                  $error("returned_to_pool: expected %0b, actual %0b",
                         want.returned, rsp_returned_to_pool);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
            end
            case (rsp_status)
               ST_NO_ID:      seen_no_id++;
               ST_STACK_FULL: seen_full++;
               ST_SATURATED:  seen_saturated++;
               default: ;
            endcase
            if (rsp_returned_to_pool === 1'b1) seen_pushed++;
         end
         if ((start && !busy) || rsp_valid) stalled_cycles <= 0;
         else stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Watchdog: give up once nothing has moved for too long.
   always @(posedge clock) begin
      if (!reset && stalled_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Present one request and hold it until the block takes the transfer.
   task automatic send_item(input logic [1:0] op, input logic [ID_W-1:0] id,
                            input logic typed, input outcome_type outcome);
      start         <= 1'b1;
      req_operation <= op;
      req_id        <= id;
      typed_valid   <= typed;
      typed_outcome <= outcome;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for a randomly sized idle burst, pct percent of the time.
   task automatic maybe_idle(input int unsigned pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Hold off the sender until every outstanding result has come back.
   task automatic drain_outcomes();
      start <= 1'b0;
      @(negedge clock);
      while (expected_outcomes.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Reference an ID that was handed out recently, or now and then any ID.
   function automatic logic [ID_W-1:0] pick_id();
      if (held_ids.size() > 0 && $urandom_range(0, 3) != 0)
         return held_ids[$urandom_range(0, held_ids.size() - 1)];
      return ID_W'($urandom_range(0, ID_COUNT - 1));
   endfunction

   initial begin
      segment_kind_type kind;
      int              seg_len;
      int unsigned     gap_pct;
      int unsigned     roll;
      int              random_sent;
      logic [1:0]      op;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] hammer_id;

      fresh_next  = 0;
      stack_depth = 0;
      foreach (holders[i]) begin
         holders[i]  = '0;
         free_ids[i] = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table; repeated rows walk the counters to their limits.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         for (int k = 0; k < DIRECTED[r].reps; k++) begin
            send_item(DIRECTED[r].op, DIRECTED[r].id, DIRECTED[r].typed, DIRECTED[r].outcome);
            maybe_idle(20);
         end
      end
      drain_outcomes();

      // Random traffic in segments, each biased toward one corner of the state.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         kind      = segment_kind_type'($urandom_range(SEG_ALLOC, SEG_NOISE));
         seg_len   = (kind == SEG_HAMMER) ? 270 : $urandom_range(20, 120);
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 20;
            default: gap_pct = 50;
         endcase
         hammer_id = pick_id();
         for (int i = 0; i < seg_len && random_sent < RANDOM_ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            id   = ID_W'($urandom_range(0, ID_COUNT - 1));
            case (kind)
               SEG_ALLOC: begin
                  if (roll < 70) op = OP_ALLOCATE;
                  else if (roll < 90) begin op = OP_RELEASE; id = pick_id(); end
                  else begin op = OP_ADD_REF; id = pick_id(); end
               end
               SEG_RELEASE: begin
                  // mostly pushes: drive the stack toward full
                  if (roll < 85) begin op = OP_RELEASE; id = pick_id(); end
                  else if (roll < 95) op = OP_ALLOCATE;
                  else begin op = OP_ADD_REF; id = pick_id(); end
               end
               SEG_REFCOUNT: begin
                  if (roll < 30) op = OP_ALLOCATE;
                  else if (roll < 65) begin op = OP_ADD_REF; id = pick_id(); end
                  else begin op = OP_RELEASE; id = pick_id(); end
               end
               SEG_HAMMER: begin
                  // pile references on one ID to drive its count toward saturation
                  op = (roll < 95) ? OP_ADD_REF : OP_RELEASE;
                  id = hammer_id;
               end
               default: op = 2'($urandom_range(0, 3));
            endcase
            send_item(op, id, 1'b0, '0);
            random_sent++;
            maybe_idle((random_sent >= RANDOM_ITEMS - QUIET_TAIL) ? 0 : gap_pct);
         end
         if (random_sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            drain_outcomes();
      end

      drain_outcomes();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests, %0d results checked; %0d IDs pushed back to the pool.",
               transfers, results, seen_pushed);
      $display("Corner hits: %0d out of IDs, %0d stack full, %0d count saturated.",
               seen_no_id, seen_full, seen_saturated);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
